// ===== rtl/core/lbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsb_pkg
// Shared types, constants and band tables for the log-band spectrum bar core.
// ----------------------------------------------------------------------------
package lbsb_pkg;

   localparam int LBSB_NUM_BANDS   = 28;
   localparam int LBSB_MAX_HEIGHT  = 123;
   localparam int LBSB_NUM_BINS    = 1024;
   localparam int LBSB_QUEUE_DEPTH = 4;

   localparam int LBSB_MAG_W   = 16;
   localparam int LBSB_BIN_W   = 10;
   localparam int LBSB_BAND_W  = 5;
   localparam int LBSB_SUM_W   = 24;
   localparam int LBSB_K_W     = 17;
   localparam int LBSB_PROD_W  = LBSB_SUM_W + LBSB_K_W;
   localparam int LBSB_FRAC_W  = 16;
   localparam int LBSB_VAL_W   = LBSB_PROD_W - LBSB_FRAC_W;
   localparam int LBSB_HGT_W   = 7;
   localparam int LBSB_SEG_W   = 5;

   // any square value at or above this saturates the bar
   localparam int LBSB_CAP_SQ = (LBSB_MAX_HEIGHT + 1) * (LBSB_MAX_HEIGHT + 1);

   // segment pitch and the reciprocal used for the divide by five
   localparam int LBSB_SEG_PITCH = 5;
   localparam int LBSB_RECIP_MUL = 205;
   localparam int LBSB_RECIP_SH  = 10;

   typedef struct packed {
      logic [LBSB_MAG_W-1:0] magnitude;
      logic                  first_bin;
   } lbsb_req_type;

   typedef struct packed {
      logic [LBSB_BAND_W-1:0] band;
      logic [LBSB_HGT_W-1:0]  height;
      logic [LBSB_SEG_W-1:0]  segments;
      logic                   last_band;
   } lbsb_rsp_type;

   // one finished band waiting for its bar height
   typedef struct packed {
      logic [LBSB_BAND_W-1:0] band;
      logic [LBSB_SUM_W-1:0]  sum;
      logic                   enable;
   } lbsb_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lbsb_queue_stat_type;

   // inclusive end bin of each band, capped at the last bin
   function automatic logic [LBSB_BIN_W-1:0] lbsb_band_end(input logic [LBSB_BAND_W-1:0] idx);
      logic [LBSB_BIN_W-1:0] e;
      case (idx)
         5'd0:    e = 10'd1;
         5'd1:    e = 10'd2;
         5'd2:    e = 10'd3;
         5'd3:    e = 10'd4;
         5'd4:    e = 10'd5;
         5'd5:    e = 10'd6;
         5'd6:    e = 10'd7;
         5'd7:    e = 10'd8;
         5'd8:    e = 10'd9;
         5'd9:    e = 10'd10;
         5'd10:   e = 10'd13;
         5'd11:   e = 10'd16;
         5'd12:   e = 10'd21;
         5'd13:   e = 10'd28;
         5'd14:   e = 10'd36;
         5'd15:   e = 10'd47;
         5'd16:   e = 10'd60;
         5'd17:   e = 10'd78;
         5'd18:   e = 10'd101;
         5'd19:   e = 10'd131;
         5'd20:   e = 10'd169;
         5'd21:   e = 10'd219;
         5'd22:   e = 10'd283;
         5'd23:   e = 10'd366;
         5'd24:   e = 10'd474;
         5'd25:   e = 10'd612;
         5'd26:   e = 10'd792;
         5'd27:   e = 10'd1023;
         default: e = '0;
      endcase
      if (e > LBSB_BIN_W'(LBSB_NUM_BINS - 1)) begin
         e = LBSB_BIN_W'(LBSB_NUM_BINS - 1);
      end
      return e;
   endfunction

   // per-band gain, unsigned fixed point UQ1.16
   function automatic logic [LBSB_K_W-1:0] lbsb_band_k(input logic [LBSB_BAND_W-1:0] idx);
      logic [LBSB_K_W-1:0] k;
      case (idx)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
         5'd5, 5'd6, 5'd7, 5'd8, 5'd9: k = 17'd96799;
         5'd10, 5'd11: k = 17'd90495;
         5'd12:   k = 17'd85713;
         5'd13:   k = 17'd81926;
         5'd14:   k = 17'd80306;
         5'd15:   k = 17'd76240;
         5'd16:   k = 17'd74028;
         5'd17:   k = 17'd69658;
         5'd18:   k = 17'd66385;
         5'd19:   k = 17'd62923;
         5'd20:   k = 17'd59959;
         5'd21:   k = 17'd56692;
         5'd22:   k = 17'd53929;
         5'd23:   k = 17'd51210;
         5'd24:   k = 17'd48654;
         5'd25:   k = 17'd46449;
         5'd26:   k = 17'd44237;
         5'd27:   k = 17'd42320;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/lbsb_front.sv =====
// ----------------------------------------------------------------------------
// lbsb_front
// Accepts bin requests, tracks bin and band position and sums each band;
// hands every finished band to the queue.
// ----------------------------------------------------------------------------
module lbsb_front
   import lbsb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lbsb_req_type        req_data,
   input  logic                csr_write,
   input  logic                csr_wdata,
   input  lbsb_queue_stat_type q_stat,
   output logic                push,
   output lbsb_job_type        push_job
);

   logic                   enable_ff, enable_in;
   logic [LBSB_BIN_W-1:0]  bin_ff, bin_in;
   logic [LBSB_BAND_W-1:0] band_ff, band_in;
   logic [LBSB_SUM_W-1:0]  sum_ff, sum_in;

   logic                   accept;
   logic                   active;
   logic [LBSB_BIN_W-1:0]  bin_next;
   logic [LBSB_SUM_W-1:0]  sum_next;
   logic                   band_done;

   // stall only on a full queue
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign active    = band_ff < LBSB_BAND_W'(LBSB_NUM_BANDS);

   // next bin position and running sum
   assign bin_next  = bin_ff + 1'b1;
   assign sum_next  = sum_ff + LBSB_SUM_W'(req_data.magnitude);
   assign band_done = (bin_next == lbsb_band_end(band_ff));

   // request classification
   always_comb begin
      bin_in  = bin_ff;
      band_in = band_ff;
      sum_in  = sum_ff;
      push    = 1'b0;
      if (accept) begin
         if (req_data.first_bin) begin
            bin_in  = '0;
            band_in = '0;
            sum_in  = '0;
         end else if (active) begin
            bin_in = bin_next;
            if (band_done) begin
               push    = 1'b1;
               sum_in  = '0;
               band_in = band_ff + 1'b1;
            end else begin
               sum_in = sum_next;
            end
         end
      end
   end

   assign push_job.band   = band_ff;
   assign push_job.sum    = sum_next;
   assign push_job.enable = enable_ff;

   assign enable_in = csr_write ? csr_wdata : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         bin_ff    <= '0;
         band_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         bin_ff    <= bin_in;
         band_ff   <= band_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

// ===== rtl/core/lbsb_queue.sv =====
// ----------------------------------------------------------------------------
// lbsb_queue
// Short first-in first-out queue of finished bands between front and back.
// ----------------------------------------------------------------------------
module lbsb_queue
   import lbsb_pkg::*;
#(
   parameter int DEPTH = LBSB_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lbsb_job_type        push_job,
   input  logic                pop,
   output lbsb_job_type        pop_job,
   output lbsb_queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lbsb_job_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_job      = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/lbsb_back.sv =====
// ----------------------------------------------------------------------------
// lbsb_back
// Turns a finished band sum into a bar height: one gain multiply, then a
// bit-per-cycle square root, then segment count and the response register.
// ----------------------------------------------------------------------------
module lbsb_back
   import lbsb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lbsb_queue_stat_type q_stat,
   input  lbsb_job_type        pop_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lbsb_rsp_type        rsp_data
);

   localparam int ROOT_CNT_W = $clog2(LBSB_HGT_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type                state_ff;
   lbsb_job_type             job_ff;
   logic [LBSB_VAL_W-1:0]    val_ff;
   logic [LBSB_HGT_W-1:0]    root_ff;
   logic [ROOT_CNT_W-1:0]    bit_ff;
   logic                     rsp_valid_ff;
   lbsb_rsp_type             rsp_ff;

   logic [LBSB_PROD_W-1:0]   product;
   logic [LBSB_HGT_W-1:0]    trial;
   logic [2*LBSB_HGT_W-1:0]  trial_sq;
   logic                     capped;
   logic [LBSB_HGT_W-1:0]    height;
   logic [LBSB_HGT_W:0]      seg_num;
   logic [LBSB_HGT_W+8:0]    seg_prod;
   logic                     slot_free;

   // gain multiply of the band sum
   assign product = LBSB_PROD_W'(job_ff.sum) * LBSB_PROD_W'(lbsb_band_k(job_ff.band));

   // one result bit per step, most significant first
   assign trial    = root_ff | (LBSB_HGT_W'(1) << bit_ff);
   assign trial_sq = (2*LBSB_HGT_W)'(trial) * (2*LBSB_HGT_W)'(trial);

   // saturation and the enable gate
   assign capped = (val_ff >= LBSB_VAL_W'(LBSB_CAP_SQ));
   always_comb begin
      if (!job_ff.enable) begin
         height = '0;
      end else if (capped) begin
         height = LBSB_HGT_W'(LBSB_MAX_HEIGHT);
      end else begin
         height = root_ff;
      end
   end

   // segments: ceil(height / 5) through a reciprocal multiply
   assign seg_num  = (LBSB_HGT_W+1)'(height) + (LBSB_HGT_W+1)'(LBSB_SEG_PITCH - 1);
   assign seg_prod = (LBSB_HGT_W+9)'(seg_num) * (LBSB_HGT_W+9)'(LBSB_RECIP_MUL);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a taken response drops unless the next one loads in its place
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  job_ff   <= pop_job;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               val_ff   <= product[LBSB_PROD_W-1:LBSB_FRAC_W];
               root_ff  <= '0;
               bit_ff   <= ROOT_CNT_W'(LBSB_HGT_W - 1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (LBSB_VAL_W'(trial_sq) <= val_ff) begin
                  root_ff <= trial;
               end
               if (bit_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.band        <= job_ff.band;
                  rsp_ff.height      <= height;
                  rsp_ff.segments    <=
                     seg_prod[LBSB_RECIP_SH +: LBSB_SEG_W];
                  rsp_ff.last_band   <=
                     (job_ff.band == LBSB_BAND_W'(LBSB_NUM_BANDS - 1));
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/log_band_spectrum_bars_core.sv =====
// ----------------------------------------------------------------------------
// log_band_spectrum_bars_core
// Sums one frame of FFT magnitude bins into 28 log-spaced bands and reports
// a bar height and segment count for each band.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one bin magnitude per request, first_bin marks bin 0 (DC),
//   which is dropped and restarts bin and band counting. Bins past the last
//   band are ignored until the next first bin.
//   rsp channel: one response per finished band (band, height, segments,
//   last_band); last_band flags the final band of the frame.
//   csr port: one bit, enable; zero forces height and segments to zero.
//   Write it only while no band is in flight.
// Timing:
//   the front takes a bin every cycle while the band queue has room.
//   Each finished band passes through the back end in order: queue pop, gain
//   multiply, 7 square-root steps, response load. The back end takes no new
//   band until the last one is loaded, so it sets the band rate; the queue
//   absorbs bursts of short bands and req_stall rises when it is full.
// Reset: counters and sum clear, enable returns to 1, no response pending.
// A stalled response holds; the back end finishes its next band and waits.
// ----------------------------------------------------------------------------
module log_band_spectrum_bars_core
   import lbsb_pkg::*;
#(
   parameter int QUEUE_DEPTH = LBSB_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lbsb_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lbsb_rsp_type rsp_data,
   input  logic         csr_write,
   input  logic         csr_wdata
);

   lbsb_queue_stat_type q_stat;
   logic                push;
   logic                pop;
   lbsb_job_type        push_job;
   lbsb_job_type        pop_job;

   // bin intake and band summing
   lbsb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   // finished bands waiting for the back end
   lbsb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   // bar height computation and response register
   lbsb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
